@@ sv/cptc_pkg.sv @@
// ----------------------------------------------------------------------------
// cptc_pkg
// Shared types and constants of the countdown / pomodoro timer control block.
// ----------------------------------------------------------------------------
package cptc_pkg;

   typedef enum logic [2:0] {
      KIND_TICK         = 3'd0,
      KIND_UP           = 3'd1,
      KIND_DOWN         = 3'd2,
      KIND_CONFIRM      = 3'd3,
      KIND_LONG_UP      = 3'd4,
      KIND_LONG_DOWN    = 3'd5,
      KIND_LONG_CONFIRM = 3'd6,
      KIND_DISARM       = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_RUN   = 2'd1,
      ST_PAUSE = 2'd2,
      ST_ALERT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_CD   = 2'd1,
      MODE_POMO = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      TILE_CLOCK = 2'd0,
      TILE_CD    = 2'd1,
      TILE_POMO  = 2'd2
   } tile_type;

   typedef enum logic [1:0] {
      PH_FOCUS = 2'd0,
      PH_SHORT = 2'd1,
      PH_LONG  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      BK_LOAD  = 2'd0,
      BK_SCALE = 2'd1,
      BK_EXEC  = 2'd2,
      BK_POST  = 2'd3
   } back_state_type;

   // which visible-state comparison sets the changed flag of a press
   typedef enum logic [1:0] {
      CMP_ALWAYS  = 2'd0,
      CMP_ALERT   = 2'd1,
      CMP_CLOCK   = 2'd2,
      CMP_GENERAL = 2'd3
   } cmp_type;

   typedef struct packed {
      kind_type    kind;
      logic        nav;
      logic        step_up;
      logic        step_big;
      logic [31:0] millis;
      logic [31:0] wall;
   } item_type;

   typedef struct packed {
      logic        changed;
      status_type  status;
      mode_type    mode;
      tile_type    tile;
      logic        in_setup;
      logic        editing;
      logic [2:0]  field;
      logic [6:0]  value;
      logic [12:0] seconds;
      phase_type   phase;
      logic [6:0]  round;
      logic        armed;
   } result_type;

   localparam logic [12:0] CD_MAX      = 13'd7200;
   localparam logic [6:0]  POMO_MIN    = 7'd1;
   localparam logic [6:0]  POMO_MAX    = 7'd99;
   localparam logic [31:0] ARM_TIMEOUT = 32'd5;
   localparam logic [31:0] WALL_MIN    = 32'd1704067200;
   localparam logic [9:0]  MS_PER_SEC  = 10'd1000;
   localparam logic [13:0] SEC_PER_HR  = 14'd3600;
   localparam logic [12:0] SEC_PER_MIN = 13'd60;
   // ceil(2^33 / 1000): exact quotient for dividends below 2^23
   localparam logic [23:0] RECIP_MS    = 24'd8589935;
   localparam logic [31:0] DIFF_LIMIT  = 32'd8192000;
   localparam logic [12:0] EL_SAT      = 13'h1FFF;

   function automatic logic [6:0] clamp_val(input logic signed [8:0] v,
                                            input logic [6:0] lo,
                                            input logic [6:0] hi);
      logic [6:0] r;
      if (v < $signed({2'b00, lo})) begin
         r = lo;
      end else if (v > $signed({2'b00, hi})) begin
         r = hi;
      end else begin
         r = v[6:0];
      end
      return r;
   endfunction

endpackage

@@ sv/countdown_pomodoro_timer_control_top.sv @@
// ----------------------------------------------------------------------------
// countdown_pomodoro_timer_control_top
// Button and tick driven countdown / pomodoro timer controller.
// ----------------------------------------------------------------------------
//   channel | ports  | direction | carries
//   --------+--------+-----------+-------------------------------------------
//   request | req_*  | in        | event kind, millisecond and wall seconds
//   result  | rsp_*  | out       | changed flag and the visible timer state
//
// Each item passes through four executor steps (load, scale the elapsed
// milliseconds by a reciprocal multiply, update state, realign and output);
// the executor takes a new item only once the last one has been output.
// A two-entry queue decouples request acceptance from execution; a waiting
// result stalls only the final step. Synchronous reset restores the default
// settings (0:05:00 countdown, 4 rounds of 25/5/15 minutes).
// ----------------------------------------------------------------------------
module countdown_pomodoro_timer_control_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_now_millis,
   input  logic [31:0] req_now_wall_seconds,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_changed,
   output logic [1:0]  rsp_run_status,
   output logic [1:0]  rsp_timer_mode,
   output logic [1:0]  rsp_view_tile,
   output logic        rsp_in_setup,
   output logic        rsp_editing_value,
   output logic [2:0]  rsp_selected_field,
   output logic [6:0]  rsp_field_value,
   output logic [12:0] rsp_seconds_left,
   output logic [1:0]  rsp_work_phase,
   output logic [6:0]  rsp_round_now,
   output logic        rsp_armed
);

   logic                 push_valid, push_ready, pop_valid, pop_ready;
   cptc_pkg::item_type   push_data, pop_data;
   cptc_pkg::result_type rsp_data;

   cptc_front u_front (
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_now_millis       (req_now_millis),
      .req_now_wall_seconds (req_now_wall_seconds),
      .push_valid           (push_valid),
      .push_ready           (push_ready),
      .push_data            (push_data)
   );

   cptc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   cptc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_changed        = rsp_data.changed;
   assign rsp_run_status     = rsp_data.status;
   assign rsp_timer_mode     = rsp_data.mode;
   assign rsp_view_tile      = rsp_data.tile;
   assign rsp_in_setup       = rsp_data.in_setup;
   assign rsp_editing_value  = rsp_data.editing;
   assign rsp_selected_field = rsp_data.field;
   assign rsp_field_value    = rsp_data.value;
   assign rsp_seconds_left   = rsp_data.seconds;
   assign rsp_work_phase     = rsp_data.phase;
   assign rsp_round_now      = rsp_data.round;
   assign rsp_armed          = rsp_data.armed;

   // an empty queue always has room
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      !pop_valid |-> req_ready)
      else $error("queue empty but request side not ready");

   a_run_has_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == cptc_pkg::ST_RUN)) |-> (rsp_seconds_left != 13'd0))
      else $error("running result with no seconds left");

   a_mode_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.mode == cptc_pkg::MODE_NONE)) |->
      (rsp_data.status == cptc_pkg::ST_IDLE))
      else $error("no timer mode while not idle");

endmodule

@@ sv/cptc_front.sv @@
// ----------------------------------------------------------------------------
// cptc_front
// Classifies each request and hands it to the queue.
// ----------------------------------------------------------------------------
module cptc_front (
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_kind,
   input  logic [31:0]         req_now_millis,
   input  logic [31:0]         req_now_wall_seconds,
   output logic                push_valid,
   input  logic                push_ready,
   output cptc_pkg::item_type  push_data
);

   cptc_pkg::kind_type kind;

   always_comb begin
      kind                = cptc_pkg::kind_type'(req_kind);
      push_data.kind      = kind;
      push_data.nav       = kind inside {cptc_pkg::KIND_UP, cptc_pkg::KIND_DOWN,
                                         cptc_pkg::KIND_LONG_UP, cptc_pkg::KIND_LONG_DOWN};
      push_data.step_up   = kind inside {cptc_pkg::KIND_UP, cptc_pkg::KIND_LONG_UP};
      push_data.step_big  = kind inside {cptc_pkg::KIND_LONG_UP, cptc_pkg::KIND_LONG_DOWN};
      push_data.millis    = req_now_millis;
      push_data.wall      = req_now_wall_seconds;
      push_valid          = req_valid;
      req_ready           = push_ready;
   end

endmodule

@@ sv/cptc_queue.sv @@
// ----------------------------------------------------------------------------
// cptc_queue
// Two-entry queue between the classifier and the executor.
// ----------------------------------------------------------------------------
module cptc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  cptc_pkg::item_type  push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output cptc_pkg::item_type  pop_data
);

   cptc_pkg::item_type entry_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push, pop;

   always_comb begin
      push_ready = (count_ff != 2'd2);
      pop_valid  = (count_ff != 2'd0);
      pop_data   = entry_ff[rd_ptr_ff];
      push       = push_valid && push_ready;
      pop        = pop_valid && pop_ready;
      wr_ptr_in  = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in   = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/cptc_back.sv @@
// ----------------------------------------------------------------------------
// cptc_back
// Executes one queued item in four steps: load, scale elapsed time,
// update timer state, realign and present the result.
// ----------------------------------------------------------------------------
module cptc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  cptc_pkg::item_type   pop_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cptc_pkg::result_type rsp_data
);

   cptc_pkg::back_state_type state_ff, state_in;
   cptc_pkg::item_type       item_ff, item_in;
   logic [46:0]              prod_ff, prod_in;
   logic                     neg_ff, neg_in, big_ff, big_in;
   logic [12:0]              el_ff, el_in;
   logic [22:0]              elk_ff, elk_in;
   logic                     el_pos_ff, el_pos_in;
   logic                     chg_ff, chg_in;

   cptc_pkg::status_type     status_ff, status_in;
   cptc_pkg::mode_type       mode_ff, mode_in;
   cptc_pkg::tile_type       tile_ff, tile_in;
   cptc_pkg::phase_type      phase_ff, phase_in;
   logic                     setup_ff, setup_in, edit_ff, edit_in;
   logic [2:0]               field_ff, field_in;
   logic                     arm_ff, arm_in;
   logic [31:0]              armed_at_ff, armed_at_in;
   logic [12:0]              remain_ff, remain_in;
   logic [31:0]              last_tick_ff, last_tick_in;
   logic [1:0]               cd_h_ff, cd_h_in;
   logic [5:0]               cd_m_ff, cd_m_in, cd_s_ff, cd_s_in;
   logic [12:0]              cd_total_ff, cd_total_in;
   logic [6:0]               rounds_ff, rounds_in, focus_ff, focus_in;
   logic [6:0]               brk_ff, brk_in, lbrk_ff, lbrk_in;
   logic [6:0]               round_ff, round_in;
   logic [32:0]              phase_end_ff, phase_end_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   cptc_pkg::result_type     rsp_ff, rsp_in;

   always_comb begin
      logic [32:0]          diff;
      logic                 chg, halt_req, clock_req, phase_req, adv_req, active, last;
      cptc_pkg::cmp_type    cmp;
      logic [2:0]           n;
      logic signed [8:0]    amt;
      logic signed [4:0]    fnext;
      logic [13:0]          tot;
      logic [33:0]          expect_v;
      logic                 rt, out_free;
      logic [6:0]           fv;

      state_in     = state_ff;
      item_in      = item_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      big_in       = big_ff;
      el_in        = el_ff;
      elk_in       = elk_ff;
      el_pos_in    = el_pos_ff;
      chg_in       = chg_ff;
      status_in    = status_ff;
      mode_in      = mode_ff;
      tile_in      = tile_ff;
      phase_in     = phase_ff;
      setup_in     = setup_ff;
      edit_in      = edit_ff;
      field_in     = field_ff;
      arm_in       = arm_ff;
      armed_at_in  = armed_at_ff;
      remain_in    = remain_ff;
      last_tick_in = last_tick_ff;
      cd_h_in      = cd_h_ff;
      cd_m_in      = cd_m_ff;
      cd_s_in      = cd_s_ff;
      cd_total_in  = cd_total_ff;
      rounds_in    = rounds_ff;
      focus_in     = focus_ff;
      brk_in       = brk_ff;
      lbrk_in      = lbrk_ff;
      round_in     = round_ff;
      phase_end_in = phase_end_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop_ready    = (state_ff == cptc_pkg::BK_LOAD);

      diff     = {1'b0, pop_data.millis} - {1'b0, last_tick_ff};
      chg      = 1'b0;
      halt_req = 1'b0;
      clock_req = 1'b0;
      phase_req = 1'b0;
      adv_req  = 1'b0;
      last     = 1'b0;
      cmp      = cptc_pkg::CMP_ALWAYS;
      active   = (mode_ff != cptc_pkg::MODE_NONE) && (status_ff != cptc_pkg::ST_IDLE);
      n        = (tile_ff == cptc_pkg::TILE_CD) ? 3'd3 :
                 (tile_ff == cptc_pkg::TILE_POMO) ? 3'd4 : 3'd0;
      amt      = item_ff.step_big ? 9'sd5 : 9'sd1;
      if (!item_ff.step_up) begin
         amt = -amt;
      end
      fnext    = $signed({2'b00, field_ff}) + (item_ff.step_up ? 5'sd1 : -5'sd1);
      tot      = 14'd0;
      expect_v = {1'b0, item_ff.wall} + {21'd0, remain_ff};
      rt       = 1'b0;
      out_free = !rsp_valid_ff || rsp_ready;
      fv       = 7'd0;

      case (state_ff)
         cptc_pkg::BK_LOAD: begin
            if (pop_valid) begin
               item_in  = pop_data;
               prod_in  = diff[22:0] * cptc_pkg::RECIP_MS;
               neg_in   = diff[32];
               big_in   = !diff[32] && (diff[31:0] >= cptc_pkg::DIFF_LIMIT);
               state_in = cptc_pkg::BK_SCALE;
            end
         end
         cptc_pkg::BK_SCALE: begin
            // saturated elapsed seconds always empty the phase
            el_in     = big_ff ? cptc_pkg::EL_SAT : prod_ff[45:33];
            elk_in    = el_in * cptc_pkg::MS_PER_SEC;
            el_pos_in = !neg_ff && (big_ff || (prod_ff[45:33] != 13'd0));
            state_in  = cptc_pkg::BK_EXEC;
         end
         cptc_pkg::BK_EXEC: begin
            case (item_ff.kind)
               cptc_pkg::KIND_TICK: begin
                  if (arm_ff && (armed_at_ff != 32'd0) && (item_ff.wall >= armed_at_ff) &&
                      ((item_ff.wall - armed_at_ff) >= cptc_pkg::ARM_TIMEOUT)) begin
                     arm_in      = 1'b0;
                     armed_at_in = 32'd0;
                     chg         = 1'b1;
                  end
                  if (status_ff == cptc_pkg::ST_RUN) begin
                     if (last_tick_ff == 32'd0) begin
                        last_tick_in = item_ff.millis;
                     end else if (el_pos_ff) begin
                        last_tick_in = last_tick_ff + {9'd0, elk_ff};
                        remain_in    = (el_ff >= remain_ff) ? 13'd0 : remain_ff - el_ff;
                        chg          = 1'b1;
                        if (remain_in == 13'd0) begin
                           status_in = cptc_pkg::ST_ALERT;
                           if (mode_ff != cptc_pkg::MODE_NONE) begin
                              tile_in = (mode_ff == cptc_pkg::MODE_POMO) ?
                                        cptc_pkg::TILE_POMO : cptc_pkg::TILE_CD;
                           end
                           setup_in    = 1'b0;
                           edit_in     = 1'b0;
                           arm_in      = 1'b0;
                           armed_at_in = 32'd0;
                        end
                     end
                  end
               end
               cptc_pkg::KIND_DISARM: begin
                  chg         = arm_ff;
                  arm_in      = 1'b0;
                  armed_at_in = 32'd0;
               end
               default: begin
                  if (item_ff.kind == cptc_pkg::KIND_LONG_CONFIRM) begin
                     if (status_ff != cptc_pkg::ST_IDLE) halt_req = 1'b1;
                     else clock_req = 1'b1;
                     chg = 1'b1;
                  end else if (active && (tile_ff == cptc_pkg::TILE_CLOCK) &&
                               (item_ff.kind inside {cptc_pkg::KIND_UP, cptc_pkg::KIND_DOWN,
                                                     cptc_pkg::KIND_CONFIRM})) begin
                     tile_in     = (mode_ff == cptc_pkg::MODE_POMO) ?
                                   cptc_pkg::TILE_POMO : cptc_pkg::TILE_CD;
                     setup_in    = 1'b0;
                     edit_in     = 1'b0;
                     arm_in      = 1'b0;
                     armed_at_in = 32'd0;
                     chg         = 1'b1;
                  end else if (status_ff == cptc_pkg::ST_ALERT) begin
                     cmp = cptc_pkg::CMP_ALERT;
                     if (item_ff.kind == cptc_pkg::KIND_CONFIRM) begin
                        if (!arm_ff) begin
                           arm_in      = 1'b1;
                           armed_at_in = item_ff.wall;
                        end else if (mode_ff == cptc_pkg::MODE_POMO) begin
                           arm_in      = 1'b0;
                           armed_at_in = 32'd0;
                           status_in   = cptc_pkg::ST_RUN;
                           adv_req     = 1'b1;
                        end else begin
                           halt_req = 1'b1;
                        end
                     end else if (arm_ff) begin
                        arm_in      = 1'b0;
                        armed_at_in = 32'd0;
                     end
                  end else if ((item_ff.kind == cptc_pkg::KIND_LONG_DOWN) &&
                               ((status_ff == cptc_pkg::ST_RUN) ||
                                (status_ff == cptc_pkg::ST_PAUSE))) begin
                     halt_req = 1'b1;
                     chg      = 1'b1;
                  end else if (tile_ff == cptc_pkg::TILE_CLOCK) begin
                     cmp = cptc_pkg::CMP_CLOCK;
                     if ((item_ff.kind == cptc_pkg::KIND_UP) ||
                         (item_ff.kind == cptc_pkg::KIND_DOWN)) begin
                        tile_in = (item_ff.kind == cptc_pkg::KIND_UP) ?
                                  cptc_pkg::TILE_CD : cptc_pkg::TILE_POMO;
                        if (status_ff == cptc_pkg::ST_IDLE) begin
                           setup_in    = 1'b1;
                           edit_in     = 1'b0;
                           field_in    = 3'd0;
                           arm_in      = 1'b0;
                           armed_at_in = 32'd0;
                        end
                     end
                  end else if (setup_ff) begin
                     chg = 1'b1;
                     if (item_ff.nav) begin
                        if (edit_ff) begin
                           if (tile_ff == cptc_pkg::TILE_CD) begin
                              case (field_ff)
                                 3'd0: cd_h_in = 2'(cptc_pkg::clamp_val(
                                          $signed({7'd0, cd_h_ff}) + amt, 7'd0, 7'd2));
                                 3'd1: cd_m_in = 6'(cptc_pkg::clamp_val(
                                          $signed({3'd0, cd_m_ff}) + amt, 7'd0, 7'd59));
                                 3'd2: cd_s_in = 6'(cptc_pkg::clamp_val(
                                          $signed({3'd0, cd_s_ff}) + amt, 7'd0, 7'd59));
                                 default: ;
                              endcase
                              tot = 14'(cd_h_in) * cptc_pkg::SEC_PER_HR +
                                    14'(cd_m_in) * 14'(cptc_pkg::SEC_PER_MIN) + 14'(cd_s_in);
                              // fields in range: only the two clamp ends renormalize
                              if (tot > 14'(cptc_pkg::CD_MAX)) begin
                                 cd_h_in     = 2'd2;
                                 cd_m_in     = 6'd0;
                                 cd_s_in     = 6'd0;
                                 cd_total_in = cptc_pkg::CD_MAX;
                              end else if (tot == 14'd0) begin
                                 cd_h_in     = 2'd0;
                                 cd_m_in     = 6'd0;
                                 cd_s_in     = 6'd1;
                                 cd_total_in = 13'd1;
                              end else begin
                                 cd_total_in = tot[12:0];
                              end
                           end else if (tile_ff == cptc_pkg::TILE_POMO) begin
                              case (field_ff)
                                 3'd0: rounds_in = cptc_pkg::clamp_val($signed({2'd0, rounds_ff})
                                          + amt, cptc_pkg::POMO_MIN, cptc_pkg::POMO_MAX);
                                 3'd1: focus_in = cptc_pkg::clamp_val($signed({2'd0, focus_ff})
                                          + amt, cptc_pkg::POMO_MIN, cptc_pkg::POMO_MAX);
                                 3'd2: brk_in = cptc_pkg::clamp_val($signed({2'd0, brk_ff})
                                          + amt, cptc_pkg::POMO_MIN, cptc_pkg::POMO_MAX);
                                 3'd3: lbrk_in = cptc_pkg::clamp_val($signed({2'd0, lbrk_ff})
                                          + amt, cptc_pkg::POMO_MIN, cptc_pkg::POMO_MAX);
                                 default: ;
                              endcase
                           end
                        end else if (n == 3'd0) begin
                           field_in = 3'd0;
                        end else if (fnext < 5'sd0) begin
                           field_in = n + 3'd1;
                        end else if (fnext > $signed({2'b00, n + 3'd1})) begin
                           field_in = 3'd0;
                        end else begin
                           field_in = fnext[2:0];
                        end
                     end else if (item_ff.kind == cptc_pkg::KIND_CONFIRM) begin
                        if (edit_ff) begin
                           edit_in = 1'b0;
                        end else if (field_ff < n) begin
                           edit_in = 1'b1;
                        end else if (field_ff == n) begin
                           if (tile_ff == cptc_pkg::TILE_CD) begin
                              mode_in   = cptc_pkg::MODE_CD;
                              remain_in = cd_total_ff;
                           end else begin
                              mode_in   = cptc_pkg::MODE_POMO;
                              phase_in  = cptc_pkg::PH_FOCUS;
                              round_in  = 7'd1;
                              remain_in = 13'(focus_ff) * cptc_pkg::SEC_PER_MIN;
                           end
                           status_in = cptc_pkg::ST_RUN;
                           setup_in  = 1'b0;
                           edit_in   = 1'b0;
                           field_in  = 3'd0;
                           phase_req = 1'b1;
                        end else if (field_ff == n + 3'd1) begin
                           clock_req = 1'b1;
                        end
                     end
                  end else if (arm_ff && item_ff.nav) begin
                     arm_in      = 1'b0;
                     armed_at_in = 32'd0;
                     chg         = 1'b1;
                  end else begin
                     cmp = cptc_pkg::CMP_GENERAL;
                     if (item_ff.kind == cptc_pkg::KIND_CONFIRM) begin
                        if (status_ff == cptc_pkg::ST_IDLE) begin
                           setup_in    = 1'b1;
                           edit_in     = 1'b0;
                           field_in    = 3'd0;
                           arm_in      = 1'b0;
                           armed_at_in = 32'd0;
                        end else if (!arm_ff) begin
                           arm_in      = 1'b1;
                           armed_at_in = item_ff.wall;
                        end else begin
                           arm_in      = 1'b0;
                           armed_at_in = 32'd0;
                           if (status_ff == cptc_pkg::ST_PAUSE) begin
                              status_in = cptc_pkg::ST_RUN;
                              phase_req = 1'b1;
                           end else if (status_ff == cptc_pkg::ST_RUN) begin
                              if ((mode_ff != cptc_pkg::MODE_POMO) ||
                                  (phase_ff == cptc_pkg::PH_FOCUS)) begin
                                 status_in = cptc_pkg::ST_PAUSE;
                              end else if (phase_ff == cptc_pkg::PH_LONG) begin
                                 halt_req = 1'b1;
                              end else begin
                                 adv_req = 1'b1;
                              end
                           end
                        end
                     end else if ((tile_ff == cptc_pkg::TILE_CD) &&
                                  (item_ff.kind == cptc_pkg::KIND_DOWN)) begin
                        clock_req = 1'b1;
                     end else if ((tile_ff == cptc_pkg::TILE_POMO) &&
                                  (item_ff.kind == cptc_pkg::KIND_UP)) begin
                        clock_req = 1'b1;
                     end
                  end
               end
            endcase

            // advance the pomodoro to its next phase
            if (adv_req) begin
               last = (round_ff >= rounds_ff);
               if (phase_ff == cptc_pkg::PH_FOCUS) begin
                  phase_in  = last ? cptc_pkg::PH_LONG : cptc_pkg::PH_SHORT;
                  remain_in = 13'(last ? lbrk_ff : brk_ff) * cptc_pkg::SEC_PER_MIN;
                  phase_req = 1'b1;
               end else if (last) begin
                  halt_req = 1'b1;
               end else begin
                  round_in  = round_ff + 7'd1;
                  phase_in  = cptc_pkg::PH_FOCUS;
                  remain_in = 13'(focus_ff) * cptc_pkg::SEC_PER_MIN;
                  phase_req = 1'b1;
               end
            end
            if (phase_req) begin
               phase_end_in = {1'b0, item_ff.wall} + {20'd0, remain_in};
               last_tick_in = 32'd0;
               arm_in       = 1'b0;
               armed_at_in  = 32'd0;
            end
            if (halt_req) begin
               status_in    = cptc_pkg::ST_IDLE;
               mode_in      = cptc_pkg::MODE_NONE;
               remain_in    = 13'd0;
               last_tick_in = 32'd0;
               phase_end_in = 33'd0;
               clock_req    = 1'b1;
            end
            if (clock_req) begin
               tile_in     = cptc_pkg::TILE_CLOCK;
               setup_in    = 1'b0;
               edit_in     = 1'b0;
               field_in    = 3'd0;
               arm_in      = 1'b0;
               armed_at_in = 32'd0;
               if ((status_in != cptc_pkg::ST_RUN) && (status_in != cptc_pkg::ST_PAUSE)) begin
                  status_in = cptc_pkg::ST_IDLE;
                  mode_in   = cptc_pkg::MODE_NONE;
                  remain_in = 13'd0;
               end
            end

            case (cmp)
               cptc_pkg::CMP_ALERT:
                  chg_in = (arm_in != arm_ff) || (status_in != status_ff) ||
                           (mode_in != mode_ff) || (phase_in != phase_ff);
               cptc_pkg::CMP_CLOCK:
                  chg_in = (tile_in != tile_ff) || (setup_in != setup_ff);
               cptc_pkg::CMP_GENERAL:
                  chg_in = (tile_in != tile_ff) || (status_in != status_ff) ||
                           (setup_in != setup_ff) || (edit_in != edit_ff) ||
                           (field_in != field_ff) || (remain_in != remain_ff) ||
                           (arm_in != arm_ff);
               default:
                  chg_in = chg;
            endcase
            state_in = cptc_pkg::BK_POST;
         end
         cptc_pkg::BK_POST: begin
            if (out_free) begin
               // keep the phase end in line with the wall clock while running
               if ((item_ff.kind == cptc_pkg::KIND_TICK) &&
                   (item_ff.wall >= cptc_pkg::WALL_MIN) &&
                   (status_ff == cptc_pkg::ST_RUN) && (remain_ff != 13'd0)) begin
                  if (phase_end_ff < {1'b0, cptc_pkg::WALL_MIN}) begin
                     rt = 1'b1;
                  end else if ((expect_v > ({1'b0, phase_end_ff} + 34'd2)) ||
                               ({1'b0, phase_end_ff} > (expect_v + 34'd2))) begin
                     rt = 1'b1;
                  end
               end
               if (rt) begin
                  phase_end_in = expect_v[32:0];
               end
               if (tile_ff == cptc_pkg::TILE_CD) begin
                  case (field_ff)
                     3'd0: fv = {5'd0, cd_h_ff};
                     3'd1: fv = {1'b0, cd_m_ff};
                     3'd2: fv = {1'b0, cd_s_ff};
                     default: fv = 7'd0;
                  endcase
               end else if (tile_ff == cptc_pkg::TILE_POMO) begin
                  case (field_ff)
                     3'd0: fv = rounds_ff;
                     3'd1: fv = focus_ff;
                     3'd2: fv = brk_ff;
                     3'd3: fv = lbrk_ff;
                     default: fv = 7'd0;
                  endcase
               end
               rsp_in.changed  = chg_ff || rt;
               rsp_in.status   = status_ff;
               rsp_in.mode     = mode_ff;
               rsp_in.tile     = tile_ff;
               rsp_in.in_setup = setup_ff;
               rsp_in.editing  = setup_ff && edit_ff;
               rsp_in.field    = field_ff;
               rsp_in.value    = fv;
               rsp_in.seconds  = remain_ff;
               rsp_in.phase    = phase_ff;
               rsp_in.round    = round_ff;
               rsp_in.armed    = arm_ff;
               rsp_valid_in    = 1'b1;
               state_in        = cptc_pkg::BK_LOAD;
            end
         end
         default: state_in = cptc_pkg::BK_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cptc_pkg::BK_LOAD;
         rsp_valid_ff <= 1'b0;
         status_ff    <= cptc_pkg::ST_IDLE;
         mode_ff      <= cptc_pkg::MODE_NONE;
         tile_ff      <= cptc_pkg::TILE_CLOCK;
         phase_ff     <= cptc_pkg::PH_FOCUS;
         setup_ff     <= 1'b0;
         edit_ff      <= 1'b0;
         field_ff     <= 3'd0;
         arm_ff       <= 1'b0;
         armed_at_ff  <= 32'd0;
         remain_ff    <= 13'd0;
         last_tick_ff <= 32'd0;
         cd_h_ff      <= 2'd0;
         cd_m_ff      <= 6'd5;
         cd_s_ff      <= 6'd0;
         cd_total_ff  <= 13'd300;
         rounds_ff    <= 7'd4;
         focus_ff     <= 7'd25;
         brk_ff       <= 7'd5;
         lbrk_ff      <= 7'd15;
         round_ff     <= 7'd1;
         phase_end_ff <= 33'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
         mode_ff      <= mode_in;
         tile_ff      <= tile_in;
         phase_ff     <= phase_in;
         setup_ff     <= setup_in;
         edit_ff      <= edit_in;
         field_ff     <= field_in;
         arm_ff       <= arm_in;
         armed_at_ff  <= armed_at_in;
         remain_ff    <= remain_in;
         last_tick_ff <= last_tick_in;
         cd_h_ff      <= cd_h_in;
         cd_m_ff      <= cd_m_in;
         cd_s_ff      <= cd_s_in;
         cd_total_ff  <= cd_total_in;
         rounds_ff    <= rounds_in;
         focus_ff     <= focus_in;
         brk_ff       <= brk_in;
         lbrk_ff      <= lbrk_in;
         round_ff     <= round_in;
         phase_end_ff <= phase_end_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      prod_ff   <= prod_in;
      neg_ff    <= neg_in;
      big_ff    <= big_in;
      el_ff     <= el_in;
      elk_ff    <= elk_in;
      el_pos_ff <= el_pos_in;
      chg_ff    <= chg_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ verif/countdown_pomodoro_timer_control_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// countdown_pomodoro_timer_control_top_tb
// Drives ticks, button presses and disarms into the timer controller. A
// predictor of the timer state computes every result. Each response transfer
// is checked field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module countdown_pomodoro_timer_control_top_tb;
   import cptc_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam longint unsigned WALL_BASE = 64'd1704067200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_kind = 3'd0;
   logic [31:0] req_now_millis = 32'd0;
   logic [31:0] req_now_wall_seconds = 32'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_changed;
   logic [1:0]  rsp_run_status;
   logic [1:0]  rsp_timer_mode;
   logic [1:0]  rsp_view_tile;
   logic        rsp_in_setup;
   logic        rsp_editing_value;
   logic [2:0]  rsp_selected_field;
   logic [6:0]  rsp_field_value;
   logic [12:0] rsp_seconds_left;
   logic [1:0]  rsp_work_phase;
   logic [6:0]  rsp_round_now;
   logic        rsp_armed;

   countdown_pomodoro_timer_control_top dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // ---- predicted timer state ----
   status_type st;
   mode_type   md;
   tile_type   tl;
   phase_type  ph;
   bit         in_menu, editing, arm_on;
   int         fidx, secs_left, cd_h, cd_m, cd_s, cd_tot;
   int         rounds, focus_min, brk_min, lbrk_min, round_no;
   bit [31:0]  armed_at, last_tick, wall;
   longint unsigned phase_end;

   result_type timer_expected[$];
   int         errors = 0;
   int         send_idle = 0;
   int         recv_stall = 0;
   int         idle_cycles = 0;
   int         sent = 0;
   bit [31:0]  ms_cur = 32'd1000;
   bit [31:0]  wall_cur = 32'd1704067200;

   function automatic int clampi(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic void set_arm(bit on);
      arm_on = on;
      armed_at = on ? wall : 32'd0;
   endfunction

   function automatic void normalize_cd();
      int t;
      t = clampi(cd_h * 3600 + cd_m * 60 + cd_s, 1, 7200);
      cd_tot = t;
      cd_h = t / 3600;
      t = t % 3600;
      cd_m = t / 60;
      cd_s = t % 60;
   endfunction

   function automatic int numeric_count();
      if (tl == TILE_CD) return 3;
      if (tl == TILE_POMO) return 4;
      return 0;
   endfunction

   function automatic void reveal();
      if (md != MODE_NONE) tl = (md == MODE_POMO) ? TILE_POMO : TILE_CD;
      in_menu = 0;
      editing = 0;
      set_arm(0);
   endfunction

   function automatic void arm_phase(int dur);
      phase_end = longint'(wall) + longint'(dur < 0 ? 0 : dur);
      last_tick = 0;
      set_arm(0);
   endfunction

   function automatic bit realign();
      longint unsigned due, diff;
      if (longint'(wall) < WALL_BASE || st != ST_RUN || secs_left <= 0) return 0;
      due = longint'(wall) + longint'(secs_left);
      if (phase_end < WALL_BASE) begin
         phase_end = due;
         return 1;
      end
      diff = due >= phase_end ? due - phase_end : phase_end - due;
      if (diff <= 2) return 0;
      phase_end = due;
      return 1;
   endfunction

   function automatic void enter_setup();
      in_menu = 1;
      editing = 0;
      fidx = 0;
      set_arm(0);
   endfunction

   function automatic void go_clock();
      tl = TILE_CLOCK;
      in_menu = 0;
      editing = 0;
      fidx = 0;
      set_arm(0);
      if (st != ST_RUN && st != ST_PAUSE) begin
         st = ST_IDLE;
         md = MODE_NONE;
         secs_left = 0;
      end
   endfunction

   function automatic void halt();
      st = ST_IDLE;
      md = MODE_NONE;
      secs_left = 0;
      last_tick = 0;
      phase_end = 0;
      set_arm(0);
      go_clock();
   endfunction

   function automatic void begin_run(int secs);
      st = ST_RUN;
      secs_left = secs;
      in_menu = 0;
      editing = 0;
      fidx = 0;
      arm_phase(secs);
   endfunction

   function automatic void toggle_run();
      if (st == ST_RUN) begin
         st = ST_PAUSE;
         set_arm(0);
      end else if (st == ST_PAUSE) begin
         st = ST_RUN;
         arm_phase(secs_left);
      end
   endfunction

   function automatic void advance_phase();
      bit last;
      if (ph == PH_FOCUS) begin
         last = round_no >= rounds;
         ph = last ? PH_LONG : PH_SHORT;
         secs_left = (last ? lbrk_min : brk_min) * 60;
         arm_phase(secs_left);
         return;
      end
      if (round_no >= rounds) begin
         halt();
         return;
      end
      round_no = (round_no + 1) & 8'h7F;
      ph = PH_FOCUS;
      secs_left = focus_min * 60;
      arm_phase(secs_left);
   endfunction

   function automatic bit tick_update(bit [31:0] ms);
      bit chg;
      longint el;
      chg = 0;
      if (arm_on && armed_at > 0 && wall >= armed_at && wall - armed_at >= 32'd5) begin
         set_arm(0);
         chg = 1;
      end
      if (st != ST_RUN) return chg;
      if (last_tick == 0) begin
         last_tick = ms;
         return realign() || chg;
      end
      el = (longint'(ms) - longint'(last_tick)) / 1000;
      if (el <= 0) return realign() || chg;
      last_tick = last_tick + 32'(el * 1000);
      secs_left = (longint'(secs_left) - el) < 0 ? 0 : int'(longint'(secs_left) - el);
      void'(realign());
      if (secs_left == 0) begin
         st = ST_ALERT;
         reveal();
      end
      return 1;
   endfunction

   function automatic bit press_update(kind_type k);
      tile_type   b_tl;
      status_type b_st;
      mode_type   b_md;
      phase_type  b_ph;
      bit b_menu, b_edit, b_arm, nav, active;
      int b_fidx, b_secs, dir, amt, n, top;
      b_tl = tl; b_st = st; b_md = md; b_ph = ph;
      b_menu = in_menu; b_edit = editing; b_arm = arm_on;
      b_fidx = fidx; b_secs = secs_left;
      nav = (k == KIND_UP || k == KIND_DOWN || k == KIND_LONG_UP || k == KIND_LONG_DOWN);
      active = md != MODE_NONE && st != ST_IDLE;

      if (k == KIND_LONG_CONFIRM) begin
         if (st != ST_IDLE) halt();
         else go_clock();
         return 1;
      end
      if (active && tl == TILE_CLOCK &&
          (k == KIND_UP || k == KIND_DOWN || k == KIND_CONFIRM)) begin
         reveal();
         return 1;
      end
      if (st == ST_ALERT) begin
         if (k == KIND_CONFIRM) begin
            if (!arm_on) set_arm(1);
            else if (md == MODE_POMO) begin
               set_arm(0);
               st = ST_RUN;
               advance_phase();
            end else halt();
         end else if (arm_on) set_arm(0);
         return b_arm != arm_on || b_st != st || b_md != md || b_ph != ph;
      end
      if (k == KIND_LONG_DOWN && (st == ST_RUN || st == ST_PAUSE)) begin
         halt();
         return 1;
      end
      if (tl == TILE_CLOCK) begin
         if (k == KIND_UP || k == KIND_DOWN) begin
            tl = (k == KIND_UP) ? TILE_CD : TILE_POMO;
            if (st == ST_IDLE) enter_setup();
         end
         return b_tl != tl || b_menu != in_menu;
      end
      if (in_menu) begin
         n = numeric_count();
         if (nav) begin
            dir = (k == KIND_UP || k == KIND_LONG_UP) ? 1 : -1;
            amt = dir * ((k == KIND_LONG_UP || k == KIND_LONG_DOWN) ? 5 : 1);
            if (editing) begin
               if (tl == TILE_CD) begin
                  if (fidx == 0) cd_h = clampi(cd_h + amt, 0, 2);
                  else if (fidx == 1) cd_m = clampi(cd_m + amt, 0, 59);
                  else if (fidx == 2) cd_s = clampi(cd_s + amt, 0, 59);
                  normalize_cd();
               end else if (tl == TILE_POMO) begin
                  if (fidx == 0) rounds = clampi(rounds + amt, 1, 99);
                  else if (fidx == 1) focus_min = clampi(focus_min + amt, 1, 99);
                  else if (fidx == 2) brk_min = clampi(brk_min + amt, 1, 99);
                  else if (fidx == 3) lbrk_min = clampi(lbrk_min + amt, 1, 99);
               end
            end else begin
               top = n > 0 ? n + 1 : 0;
               if (top <= 0) fidx = 0;
               else begin
                  fidx += dir;
                  if (fidx < 0) fidx = top;
                  else if (fidx > top) fidx = 0;
               end
            end
         end else if (k == KIND_CONFIRM) begin
            if (editing) editing = 0;
            else if (fidx < n) editing = 1;
            else if (fidx == n) begin
               if (tl == TILE_CD) begin
                  normalize_cd();
                  md = MODE_CD;
                  begin_run(cd_tot);
               end else if (tl == TILE_POMO) begin
                  rounds = clampi(rounds, 1, 99);
                  focus_min = clampi(focus_min, 1, 99);
                  brk_min = clampi(brk_min, 1, 99);
                  lbrk_min = clampi(lbrk_min, 1, 99);
                  md = MODE_POMO;
                  ph = PH_FOCUS;
                  round_no = 1;
                  begin_run(focus_min * 60);
               end
            end else if (fidx == n + 1) go_clock();
         end
         return 1;
      end
      if (arm_on && nav) begin
         set_arm(0);
         return 1;
      end
      if (k == KIND_CONFIRM) begin
         if (st == ST_IDLE) enter_setup();
         else if (!arm_on) set_arm(1);
         else begin
            // primary action on second confirm
            set_arm(0);
            if (st == ST_PAUSE) toggle_run();
            else if (st == ST_RUN) begin
               if (md != MODE_POMO || ph == PH_FOCUS) toggle_run();
               else if (ph == PH_LONG) halt();
               else advance_phase();
            end
         end
      end else if (tl == TILE_CD && k == KIND_DOWN) go_clock();
      else if (tl == TILE_POMO && k == KIND_UP) go_clock();
      return b_tl != tl || b_st != st || b_menu != in_menu || b_edit != editing ||
             b_fidx != fidx || b_secs != secs_left || b_arm != arm_on;
   endfunction

   function automatic result_type predict_timer(kind_type k, bit [31:0] ms, bit [31:0] w);
      result_type r;
      int fv;
      wall = w;
      if (k == KIND_TICK) r.changed = tick_update(ms);
      else if (k == KIND_DISARM) begin
         r.changed = arm_on;
         set_arm(0);
      end else r.changed = press_update(k);
      fv = 0;
      if (tl == TILE_CD) begin
         if (fidx == 0) fv = cd_h;
         else if (fidx == 1) fv = cd_m;
         else if (fidx == 2) fv = cd_s;
      end else if (tl == TILE_POMO) begin
         if (fidx == 0) fv = rounds;
         else if (fidx == 1) fv = focus_min;
         else if (fidx == 2) fv = brk_min;
         else if (fidx == 3) fv = lbrk_min;
      end
      r.status   = st;
      r.mode     = md;
      r.tile     = tl;
      r.in_setup = in_menu;
      r.editing  = in_menu && editing;
      r.field    = 3'(fidx);
      r.value    = 7'(fv);
      r.seconds  = 13'(secs_left);
      r.phase    = ph;
      r.round    = 7'(round_no);
      r.armed    = arm_on;
      return r;
   endfunction

   function automatic void reset_timer_model();
      st = ST_IDLE; md = MODE_NONE; tl = TILE_CLOCK; ph = PH_FOCUS;
      in_menu = 0; editing = 0; fidx = 0; arm_on = 0;
      armed_at = 0; secs_left = 0; last_tick = 0;
      cd_h = 0; cd_m = 5; cd_s = 0; cd_tot = 300;
      rounds = 4; focus_min = 25; brk_min = 5; lbrk_min = 15;
      round_no = 1; phase_end = 0; wall = 0;
   endfunction

   // ---- checking ----
   task automatic report_mismatch(string what, int got, int want);
      $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (timer_expected.size() == 0) begin
            $display("[%0t] response transfer with nothing expected", $time);
            errors++;
         end else begin
            e = timer_expected.pop_front();
            if (rsp_changed !== e.changed) report_mismatch("changed", rsp_changed, e.changed);
            if (rsp_run_status !== e.status)
               report_mismatch("run_status", rsp_run_status, e.status);
            if (rsp_timer_mode !== e.mode) report_mismatch("timer_mode", rsp_timer_mode, e.mode);
            if (rsp_view_tile !== e.tile) report_mismatch("view_tile", rsp_view_tile, e.tile);
            if (rsp_in_setup !== e.in_setup)
               report_mismatch("in_setup", rsp_in_setup, e.in_setup);
            if (rsp_editing_value !== e.editing)
               report_mismatch("editing_value", rsp_editing_value, e.editing);
            if (rsp_selected_field !== e.field)
               report_mismatch("selected_field", rsp_selected_field, e.field);
            if (rsp_field_value !== e.value)
               report_mismatch("field_value", rsp_field_value, e.value);
            if (rsp_seconds_left !== e.seconds)
               report_mismatch("seconds_left", rsp_seconds_left, e.seconds);
            if (rsp_work_phase !== e.phase) report_mismatch("work_phase", rsp_work_phase, e.phase);
            if (rsp_round_now !== e.round) report_mismatch("round_now", rsp_round_now, e.round);
            if (rsp_armed !== e.armed) report_mismatch("armed", rsp_armed, e.armed);
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // ---- stimulus ----
   task automatic send_item(kind_type k, bit [31:0] ms, bit [31:0] w);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= k;
      req_now_millis <= ms;
      req_now_wall_seconds <= w;
      do @(posedge clock); while (!req_ready);
      timer_expected.push_back(predict_timer(k, ms, w));
      sent++;
   endtask

   task automatic press(kind_type k);
      wall_cur += $urandom_range(2);
      send_item(k, $urandom, wall_cur);
   endtask

   task automatic tick(int unsigned delta);
      ms_cur += delta;
      wall_cur += $urandom_range(2);
      send_item(KIND_TICK, ms_cur, wall_cur);
   endtask

   // Drop valid, then hold until every expected result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (timer_expected.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Configure a short session from the clock tile and start it.
   task automatic start_session(bit pomo);
      int cuts;
      press(KIND_LONG_CONFIRM);
      press(pomo ? KIND_DOWN : KIND_UP);
      press(KIND_UP);                        // second numeric field
      press(KIND_CONFIRM);
      cuts = $urandom_range(25);
      repeat (cuts) press(KIND_LONG_DOWN);
      if ($urandom_range(1)) press(KIND_UP);
      press(KIND_CONFIRM);
      if (pomo) begin
         press(KIND_DOWN);                   // back to rounds
         press(KIND_CONFIRM);
         repeat ($urandom_range(20)) press(KIND_LONG_DOWN);
         press(KIND_CONFIRM);
         repeat (4) press(KIND_UP);          // start field
      end else begin
         repeat (2) press(KIND_UP);          // start field
      end
      press(KIND_CONFIRM);
   endtask

   task automatic random_item();
      int sel;
      sel = $urandom_range(99);
      if (sel < 35) begin
         case ($urandom_range(9))
            0: tick(0);
            1: tick($urandom);               // wild jump, also backwards
            2, 3: tick($urandom_range(70000, 1000));
            4: begin
               wall_cur = $urandom;
               send_item(KIND_TICK, $urandom, wall_cur);
            end
            default: tick($urandom_range(2500));
         endcase
      end else if (sel < 60) press(KIND_CONFIRM);
      else if (sel < 70) press(KIND_UP);
      else if (sel < 80) press(KIND_DOWN);
      else if (sel < 85) press(KIND_LONG_UP);
      else if (sel < 90) press(KIND_LONG_DOWN);
      else if (sel < 93) press(KIND_LONG_CONFIRM);
      else press(KIND_DISARM);
      if ($urandom_range(99) < 3) wall_cur = $urandom_range(1) ? 32'd0 : $urandom;
      if ($urandom_range(99) < 5) wall_cur = 32'd1704067200 + $urandom_range(100000);
   endtask

   task automatic test_directed();
      send_item(KIND_TICK, 32'd0, 32'd0);
      send_item(KIND_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(KIND_DISARM, 32'hFFFF_FFFF, 32'd0);
      press(KIND_UP);                        // countdown setup
      press(KIND_CONFIRM);
      press(KIND_LONG_UP);
      press(KIND_LONG_UP);
      press(KIND_CONFIRM);
      press(KIND_DOWN);
      press(KIND_DOWN);
      press(KIND_CONFIRM);                   // start the countdown
      send_item(KIND_TICK, 32'd5000, 32'd0);
      send_item(KIND_TICK, 32'd2000, 32'd0);  // millis behind last tick
      send_item(KIND_CONFIRM, 32'd0, 32'd0);  // arm at wall second zero
      send_item(KIND_TICK, 32'd9000, 32'd100);
      send_item(KIND_DISARM, 32'd0, 32'd100);
      send_item(KIND_CONFIRM, 32'd0, 32'd100);
      send_item(KIND_TICK, 32'd9500, 32'd106); // arm times out
      send_item(KIND_TICK, 32'hFFFF_FF00, 32'hFFFF_FFFF);
      press(KIND_CONFIRM);
      press(KIND_CONFIRM);
      press(KIND_LONG_DOWN);
      press(KIND_DOWN);
      press(KIND_LONG_CONFIRM);
      drain();
   endtask

   task automatic test_random(int items, int idle_pct, int stall_pct);
      int start;
      send_idle = idle_pct;
      recv_stall = stall_pct;
      start = sent;
      while (sent - start < items) begin
         if ($urandom_range(99) < 8) begin
            start_session($urandom_range(1));
         end else begin
            random_item();
         end
      end
      drain();
   endtask

   initial begin
      reset_timer_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(380, 0, 0);
      test_random(380, 53, 0);
      test_random(380, 0, 53);
      test_random(380, 11, 11);
      recv_stall = 0;
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
